@@ design/trsm_pkg.sv @@
// ----------------------------------------------------------------------------
// trsm_pkg
// Shared types and constants of the tiled reshape segment mapper.
// ----------------------------------------------------------------------------
package trsm_pkg;

  localparam int TILE_ROWS_DEF = 32;
  localparam int TILE_COLS_DEF = 32;
  localparam int FACE_ROWS_DEF = 16;
  localparam int FACE_COLS_DEF = 16;

  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int OFS_W    = 10;
  localparam int LEN_W    = 11;
  localparam int PAGE_W   = 32;
  localparam int DIM_W    = 16;
  localparam int POS_W    = 5;
  localparam int MAX_RUN  = 1024;
  localparam int QDEPTH   = 2;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] in_height;
    logic [DIM_W-1:0] in_width;
    logic [DIM_W-1:0] out_height;
    logic [DIM_W-1:0] out_width;
  } cfg_t;

  // one mapped element, front to back
  typedef struct packed {
    logic [PAGE_W-1:0] in_page;
    logic [OFS_W-1:0]  in_offset;
    logic [OFS_W-1:0]  out_offset;
    logic              page_end;
  } work_t;

  typedef struct packed {
    logic [PAGE_W-1:0] in_page;
    logic [OFS_W-1:0]  in_offset;
    logic [OFS_W-1:0]  out_offset;
    logic [LEN_W-1:0]  seg_length;
    logic              seg_last;
  } seg_t;

  typedef enum logic [2:0] {
    FE_IDLE, FE_ISSUE, FE_WAIT, FE_WB, FE_PUSH
  } fe_state_t;

  typedef enum logic [4:0] {
    ST_OTW, ST_OTH, ST_ITW, ST_ITH, ST_OTC, ST_ITC, ST_PAGE, ST_REM,
    ST_HO, ST_WO, ST_OHW, ST_FLAT0, ST_FLAT1, ST_IHW, ST_FLAT_DIV, ST_HW,
    ST_HI, ST_WI, ST_IPG0, ST_IPG1, ST_HO_T, ST_WO_T, ST_IH_F, ST_IW_F,
    ST_OH_F, ST_OW_F
  } step_t;

  // steps that divide by a shape-dependent value
  function automatic logic step_is_div(input step_t s);
    return (s == ST_PAGE) || (s == ST_REM) || (s == ST_FLAT_DIV) || (s == ST_HW);
  endfunction

endpackage

@@ design/trsm_if.sv @@
// ----------------------------------------------------------------------------
// trsm_in_if / trsm_out_if
// Valid/ready channels for element positions and segments.
// ----------------------------------------------------------------------------
interface trsm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_page;
  logic [4:0]  tile_row;
  logic [4:0]  tile_col;
  logic        page_end;
  modport source (output valid, output out_page, output tile_row, output tile_col,
                  output page_end, input ready);
  modport sink (input valid, input out_page, input tile_row, input tile_col,
                input page_end, output ready);
endinterface

interface trsm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_page;
  logic [9:0]  in_offset;
  logic [9:0]  out_offset;
  logic [10:0] seg_length;
  logic        seg_last;
  modport source (output valid, output in_page, output in_offset, output out_offset,
                  output seg_length, output seg_last, input ready);
  modport sink (input valid, input in_page, input in_offset, input out_offset,
                input seg_length, input seg_last, output ready);
endinterface

@@ design/trsm_div.sv @@
// ----------------------------------------------------------------------------
// trsm_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module trsm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [trsm_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [trsm_pkg::DIVISOR_W-1:0]  divisor,
  output logic                            done,
  output logic [trsm_pkg::DIVIDEND_W-1:0] quo,
  output logic [trsm_pkg::DIVISOR_W-1:0]  rmd
);
  import trsm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // trial subtract of the next partial remainder
  always_comb begin
    shifted = {rmd, quo[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rmd  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DIVIDEND_W-2:0], ge};
        rmd <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ design/trsm_queue.sv @@
// ----------------------------------------------------------------------------
// trsm_queue
// Short queue of mapped elements between the front and the back.
// ----------------------------------------------------------------------------
module trsm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  trsm_pkg::work_t  push_data,
  output logic             push_ready,
  input  logic             pop,
  output trsm_pkg::work_t  pop_data,
  output logic             pop_valid
);
  import trsm_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  work_t         mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != (PW+1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end
endmodule

@@ design/trsm_front.sv @@
// ----------------------------------------------------------------------------
// trsm_front
// Sequencer that maps one element position to its input page and the
// face-ordered offsets, using one shared divider and one multiplier.
// ----------------------------------------------------------------------------
module trsm_front #(
  parameter int TILE_ROWS = trsm_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = trsm_pkg::TILE_COLS_DEF,
  parameter int FACE_ROWS = trsm_pkg::FACE_ROWS_DEF,
  parameter int FACE_COLS = trsm_pkg::FACE_COLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  trsm_pkg::cfg_t   cfg,
  trsm_in_if.sink          in_ch,
  output logic             push,
  output trsm_pkg::work_t  push_data,
  input  logic             push_ready
);
  import trsm_pkg::*;

  localparam int TMAX    = (TILE_ROWS > TILE_COLS) ? TILE_ROWS : TILE_COLS;
  localparam int RB      = $clog2(TMAX) + 1;
  localparam int HO_W    = DIM_W + $clog2(TILE_ROWS) + 1;
  localparam int WO_W    = DIM_W + $clog2(TILE_COLS) + 1;
  localparam int FACES_W = TILE_COLS / FACE_COLS;
  localparam int FACE_SZ = FACE_ROWS * FACE_COLS;

  // tile and face sizes are powers of two: those divisions are shifts and masks
  localparam int TR_SH = $clog2(TILE_ROWS);
  localparam int TC_SH = $clog2(TILE_COLS);
  localparam int FR_SH = $clog2(FACE_ROWS);
  localparam int FC_SH = $clog2(FACE_COLS);

  fe_state_t state, state_next;
  step_t     step;

  // captured item
  logic [PAGE_W-1:0] page;
  logic [POS_W-1:0]  trow;
  logic [POS_W-1:0]  tcol;
  logic              pend;

  // intermediate values
  logic [DIM_W-1:0]  otw, oth, itw, ith;
  logic [31:0]       otc, itc;
  logic [31:0]       co, rem;
  logic [DIM_W-1:0]  rq, rr;
  logic [HO_W-1:0]   ho;
  logic [WO_W-1:0]   wo;
  logic [31:0]       ohw, ihw;
  logic [63:0]       flat;
  logic [31:0]       ci, hw;
  logic [DIM_W-1:0]  hi, wi, hq, wq;
  logic [RB-1:0]     ihr, iwr, ohr, owr;
  logic [RB-1:0]     ihf, ihfr, iwf, iwfr, ohf, ohfr, owf, owfr;
  logic [PAGE_W-1:0] ipage;

  // shared arithmetic
  logic [DIVIDEND_W-1:0] div_a;
  logic [DIVISOR_W-1:0]  div_b;
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rmd;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod;

  function automatic logic [OFS_W-1:0] faced(input logic [RB-1:0] hf, input logic [RB-1:0] wf,
                                             input logic [RB-1:0] fh, input logic [RB-1:0] fw);
    logic [31:0] o;
    o = (32'(hf) * 32'(FACES_W) + 32'(wf)) * 32'(FACE_SZ) + 32'(fh) * 32'(FACE_COLS)
        + 32'(fw);
    return o[OFS_W-1:0];
  endfunction

  trsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (quo),
    .rmd      (rmd)
  );

  // operand selection per step
  always_comb begin
    div_a = '0;
    div_b = 32'd1;
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      ST_OTC:      begin mul_a = 32'(oth); mul_b = 32'(otw); end
      ST_ITC:      begin mul_a = 32'(ith); mul_b = 32'(itw); end
      ST_PAGE:     begin div_a = 64'(page); div_b = otc; end
      ST_REM:      begin div_a = 64'(rem); div_b = 32'(otw); end
      ST_HO:       begin mul_a = 32'(rq); mul_b = 32'(TILE_ROWS); end
      ST_WO:       begin mul_a = 32'(rr); mul_b = 32'(TILE_COLS); end
      ST_OHW:      begin mul_a = 32'(cfg.out_height); mul_b = 32'(cfg.out_width); end
      ST_FLAT0:    begin mul_a = co; mul_b = ohw; end
      ST_FLAT1:    begin mul_a = 32'(ho); mul_b = 32'(cfg.out_width); end
      ST_IHW:      begin mul_a = 32'(cfg.in_height); mul_b = 32'(cfg.in_width); end
      ST_FLAT_DIV: begin div_a = flat; div_b = ihw; end
      ST_HW:       begin div_a = 64'(hw); div_b = 32'(cfg.in_width); end
      ST_IPG0:     begin mul_a = ci; mul_b = itc; end
      ST_IPG1:     begin mul_a = 32'(hq); mul_b = 32'(itw); end
      default:     ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next  = state;
    div_start   = 1'b0;
    in_ch.ready = 1'b0;
    push        = 1'b0;
    unique case (state)
      FE_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_next = FE_ISSUE;
      end
      FE_ISSUE: begin
        if (step_is_div(step)) begin
          div_start  = 1'b1;
          state_next = FE_WAIT;
        end else begin
          state_next = FE_WB;
        end
      end
      FE_WAIT: begin
        if (div_done) state_next = FE_WB;
      end
      FE_WB: begin
        state_next = (step == ST_OW_F) ? FE_PUSH : FE_ISSUE;
      end
      FE_PUSH: begin
        push = 1'b1;
        if (push_ready) state_next = FE_IDLE;
      end
      default: state_next = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
      step  <= ST_OTW;
    end else begin
      state <= state_next;
      if (state == FE_IDLE) begin
        step <= ST_OTW;
      end else if (state == FE_WB && step != ST_OW_F) begin
        step <= step_t'(step + 1'b1);
      end
    end
  end

  // multiplier result register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // item capture and step write-back
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      page <= in_ch.out_page;
      trow <= in_ch.tile_row;
      tcol <= in_ch.tile_col;
      pend <= in_ch.page_end;
    end
    if (state == FE_WB) begin
      unique case (step)
        ST_OTW:      otw <= DIM_W'(({1'b0, cfg.out_width} + (DIM_W+1)'(TILE_COLS - 1))
                                   >> TC_SH);
        ST_OTH:      oth <= DIM_W'(({1'b0, cfg.out_height} + (DIM_W+1)'(TILE_ROWS - 1))
                                   >> TR_SH);
        ST_ITW:      itw <= DIM_W'(({1'b0, cfg.in_width} + (DIM_W+1)'(TILE_COLS - 1))
                                   >> TC_SH);
        ST_ITH:      ith <= DIM_W'(({1'b0, cfg.in_height} + (DIM_W+1)'(TILE_ROWS - 1))
                                   >> TR_SH);
        ST_OTC:      otc <= prod[31:0];
        ST_ITC:      itc <= prod[31:0];
        ST_PAGE:     begin co <= quo[31:0]; rem <= rmd; end
        ST_REM:      begin rq <= quo[DIM_W-1:0]; rr <= rmd[DIM_W-1:0]; end
        ST_HO:       ho <= HO_W'(prod + 64'(trow));
        ST_WO:       wo <= WO_W'(prod + 64'(tcol));
        ST_OHW:      ohw <= prod[31:0];
        ST_FLAT0:    flat <= prod;
        ST_FLAT1:    flat <= flat + prod + 64'(wo);
        ST_IHW:      ihw <= prod[31:0];
        ST_FLAT_DIV: begin ci <= quo[31:0]; hw <= rmd; end
        ST_HW:       begin hi <= quo[DIM_W-1:0]; wi <= rmd[DIM_W-1:0]; end
        ST_HI:       begin
          hq  <= hi >> TR_SH;
          ihr <= RB'(hi & DIM_W'(TILE_ROWS - 1));
        end
        ST_WI:       begin
          wq  <= wi >> TC_SH;
          iwr <= RB'(wi & DIM_W'(TILE_COLS - 1));
        end
        ST_IPG0:     ipage <= prod[31:0];
        ST_IPG1:     ipage <= ipage + prod[31:0] + 32'(wq);
        ST_HO_T:     ohr <= RB'(ho & HO_W'(TILE_ROWS - 1));
        ST_WO_T:     owr <= RB'(wo & WO_W'(TILE_COLS - 1));
        ST_IH_F:     begin ihf <= ihr >> FR_SH; ihfr <= ihr & RB'(FACE_ROWS - 1); end
        ST_IW_F:     begin iwf <= iwr >> FC_SH; iwfr <= iwr & RB'(FACE_COLS - 1); end
        ST_OH_F:     begin ohf <= ohr >> FR_SH; ohfr <= ohr & RB'(FACE_ROWS - 1); end
        ST_OW_F:     begin owf <= owr >> FC_SH; owfr <= owr & RB'(FACE_COLS - 1); end
        default:     ;
      endcase
    end
  end

  // mapped element toward the queue
  always_comb begin
    push_data.in_page    = ipage;
    push_data.in_offset  = faced(ihf, iwf, ihfr, iwfr);
    push_data.out_offset = faced(ohf, owf, ohfr, owfr);
    push_data.page_end   = pend;
  end
endmodule

@@ design/trsm_back.sv @@
// ----------------------------------------------------------------------------
// trsm_back
// Merges mapped elements into runs and emits finished segments.
// ----------------------------------------------------------------------------
module trsm_back (
  input  logic             clk,
  input  logic             rst,
  input  trsm_pkg::work_t  pop_data,
  input  logic             pop_valid,
  output logic             pop,
  trsm_out_if.source       out_ch
);
  import trsm_pkg::*;

  // open run
  logic              open_valid;
  logic [PAGE_W-1:0] open_in_page;
  logic [OFS_W-1:0]  open_in_start;
  logic [OFS_W-1:0]  open_out_start;
  logic [LEN_W-1:0]  open_count;
  logic [OFS_W-1:0]  last_in_offset;
  logic [OFS_W-1:0]  last_out_offset;

  // output register and second-segment hold
  logic  out_v;
  seg_t  out_seg;
  logic  hold_v;
  seg_t  hold_seg;

  logic  merge;
  seg_t  brk_seg;
  seg_t  end_seg;
  logic [LEN_W-1:0] count_next;

  assign pop = pop_valid && !hold_v && (!out_v || out_ch.ready);

  // run merge decision
  always_comb begin
    merge = open_valid && (pop_data.in_page == open_in_page)
            && ({1'b0, pop_data.in_offset} == {1'b0, last_in_offset} + 11'd1)
            && ({1'b0, pop_data.out_offset} == {1'b0, last_out_offset} + 11'd1)
            && (open_count < LEN_W'(MAX_RUN));
    count_next = merge ? open_count + 1'b1 : LEN_W'(1);

    brk_seg.in_page    = open_in_page;
    brk_seg.in_offset  = open_in_start;
    brk_seg.out_offset = open_out_start;
    brk_seg.seg_length = open_count;
    brk_seg.seg_last   = 1'b0;

    end_seg.in_page    = merge ? open_in_page : pop_data.in_page;
    end_seg.in_offset  = merge ? open_in_start : pop_data.in_offset;
    end_seg.out_offset = merge ? open_out_start : pop_data.out_offset;
    end_seg.seg_length = count_next;
    end_seg.seg_last   = 1'b1;
  end

  // open run state
  always_ff @(posedge clk) begin
    if (rst) begin
      open_valid      <= 1'b0;
      open_in_page    <= '0;
      open_in_start   <= '0;
      open_out_start  <= '0;
      open_count      <= '0;
      last_in_offset  <= '0;
      last_out_offset <= '0;
    end else if (pop) begin
      if (!merge) begin
        open_in_page   <= pop_data.in_page;
        open_in_start  <= pop_data.in_offset;
        open_out_start <= pop_data.out_offset;
      end
      open_count      <= count_next;
      open_valid      <= !pop_data.page_end;
      last_in_offset  <= pop_data.in_offset;
      last_out_offset <= pop_data.out_offset;
    end
  end

  // segment output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      hold_v <= 1'b0;
    end else if (pop) begin
      priority if (!merge && open_valid && pop_data.page_end) begin
        out_v    <= 1'b1;
        out_seg  <= brk_seg;
        hold_v   <= 1'b1;
        hold_seg <= end_seg;
      end else if (!merge && open_valid) begin
        out_v   <= 1'b1;
        out_seg <= brk_seg;
      end else if (pop_data.page_end) begin
        out_v   <= 1'b1;
        out_seg <= end_seg;
      end else begin
        out_v <= 1'b0;
      end
    end else if (out_v && out_ch.ready) begin
      if (hold_v) begin
        out_seg <= hold_seg;
        hold_v  <= 1'b0;
      end else begin
        out_v <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_v;
  assign out_ch.in_page    = out_seg.in_page;
  assign out_ch.in_offset  = out_seg.in_offset;
  assign out_ch.out_offset = out_seg.out_offset;
  assign out_ch.seg_length = out_seg.seg_length;
  assign out_ch.seg_last   = out_seg.seg_last;
endmodule

@@ design/tiled_reshape_segment_mapper_top.sv @@
// ----------------------------------------------------------------------------
// tiled_reshape_segment_mapper_top
// Maps output tile element positions to input pages and merges runs.
// ----------------------------------------------------------------------------
// sequence: each accepted element beat runs four divisions and 22 other
//   steps before the segment beats it releases
// a new element beat is taken only once the last one is pushed to the queue
// reset: synchronous, clears control, shape registers return to 32
module tiled_reshape_segment_mapper_top #(
  parameter int TILE_ROWS = trsm_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = trsm_pkg::TILE_COLS_DEF,
  parameter int FACE_ROWS = trsm_pkg::FACE_ROWS_DEF,
  parameter int FACE_COLS = trsm_pkg::FACE_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [trsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trsm_pkg::DIM_W-1:0]      cfg_wdata,
  trsm_in_if.sink                         in_ch,
  trsm_out_if.source                      out_ch
);
  import trsm_pkg::*;

  cfg_t  regs;
  cfg_t  cfg;
  logic  push, push_ready, pop, pop_valid;
  work_t push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.in_height  <= DIM_W'(32);
      regs.in_width   <= DIM_W'(32);
      regs.out_height <= DIM_W'(32);
      regs.out_width  <= DIM_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_HEIGHT:  regs.in_height  <= cfg_wdata;
        CFG_IN_WIDTH:   regs.in_width   <= cfg_wdata;
        CFG_OUT_HEIGHT: regs.out_height <= cfg_wdata;
        CFG_OUT_WIDTH:  regs.out_width  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a zero shape acts as one
  always_comb begin
    cfg.in_height  = (regs.in_height  == '0) ? DIM_W'(1) : regs.in_height;
    cfg.in_width   = (regs.in_width   == '0) ? DIM_W'(1) : regs.in_width;
    cfg.out_height = (regs.out_height == '0) ? DIM_W'(1) : regs.out_height;
    cfg.out_width  = (regs.out_width  == '0) ? DIM_W'(1) : regs.out_width;
  end

  trsm_front #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS),
    .FACE_ROWS (FACE_ROWS),
    .FACE_COLS (FACE_COLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  trsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid)
  );

  trsm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop       (pop),
    .out_ch    (out_ch)
  );
endmodule

@@ design/trsm_checker.sv @@
// ----------------------------------------------------------------------------
// trsm_checker
// Port-level checks on the segment output of the mapper.
// ----------------------------------------------------------------------------
module trsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  in_offset,
  input logic [9:0]  out_offset,
  input logic [10:0] seg_length
);
  // a stalled beat keeps its length
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seg_length))
    else $error("segment beat changed while stalled");

  // no beat right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("segment valid after reset");

  // length is within one run
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seg_length != 11'd0 && seg_length <= 11'd1024)
    else $error("segment length out of range");

  // a run never wraps past the end of a tile
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({2'b0, in_offset} + {1'b0, seg_length} <= 12'd1024)
               && ({2'b0, out_offset} + {1'b0, seg_length} <= 12'd1024))
    else $error("segment run wraps offset");
endmodule

bind tiled_reshape_segment_mapper_top trsm_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .in_offset  (out_ch.in_offset),
  .out_offset (out_ch.out_offset),
  .seg_length (out_ch.seg_length)
);

@@ test/trsm_segment_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsm_segment_checker
// Watches the shape register port and both channels, predicts the segments
// of every accepted element beat and compares each segment beat field by
// field with the oldest predicted one.
// ----------------------------------------------------------------------------
module trsm_segment_checker
  import trsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  trsm_in_if                   in_mon,
  trsm_out_if                  out_mon,
  output int                   fail_count,
  output int                   pending
);

  localparam int TR = TILE_ROWS_DEF;
  localparam int TC = TILE_COLS_DEF;
  localparam int FR = FACE_ROWS_DEF;
  localparam int FC = FACE_COLS_DEF;

  // shadow of the shape registers
  bit [DIM_W-1:0] shape_in_h, shape_in_w, shape_out_h, shape_out_w;

  // open run being merged
  bit              run_open;
  bit [PAGE_W-1:0] run_page;
  bit [OFS_W-1:0]  run_in_start, run_out_start;
  int              run_len;
  bit [OFS_W-1:0]  prev_in_ofs, prev_out_ofs;

  seg_t segs_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // zero shape acts as one
  function automatic bit [63:0] dim_or_one(bit [DIM_W-1:0] v);
    return (v == 0) ? 64'd1 : 64'(v);
  endfunction

  function automatic bit [63:0] div_up(bit [63:0] a, bit [63:0] b);
    return (a + b - 1) / b;
  endfunction

  function automatic bit [OFS_W-1:0] face_ofs(bit [63:0] h, bit [63:0] w);
    bit [63:0] rh, rw, o;
    rh = h % TR;
    rw = w % TC;
    o  = ((rh / FR) * (TC / FC) + rw / FC) * (FR * FC) + (rh % FR) * FC + rw % FC;
    return o[OFS_W-1:0];
  endfunction

  function automatic seg_t close_run(bit last);
    seg_t s;
    s.in_page    = run_page;
    s.in_offset  = run_in_start;
    s.out_offset = run_out_start;
    s.seg_length = LEN_W'(run_len);
    s.seg_last   = last;
    return s;
  endfunction

  // append one predicted segment
  function automatic void add_due(seg_t s);
    segs_due.insert(segs_due.size(), s);
  endfunction

  // map one element position and update the open run
  task automatic take_element(bit [31:0] page, bit [4:0] row, bit [4:0] col, bit pend);
    bit [63:0] oh, ow, ih, iw, otw, otc, itw, itc;
    bit [63:0] co, rem, ho, wo, flat, ci, hw, hi, wi, pg;
    bit [OFS_W-1:0] iofs, oofs;
    bit joins;
    oh  = dim_or_one(shape_out_h);
    ow  = dim_or_one(shape_out_w);
    ih  = dim_or_one(shape_in_h);
    iw  = dim_or_one(shape_in_w);
    otw = div_up(ow, TC);
    otc = div_up(oh, TR) * otw;
    itw = div_up(iw, TC);
    itc = div_up(ih, TR) * itw;
    co  = 64'(page) / otc;
    rem = 64'(page) % otc;
    ho  = (rem / otw) * TR + 64'(row);
    wo  = (rem % otw) * TC + 64'(col);
    flat = co * oh * ow + ho * ow + wo;
    ci  = flat / (ih * iw);
    hw  = flat % (ih * iw);
    hi  = hw / iw;
    wi  = hw % iw;
    pg  = ci * itc + (hi / TR) * itw + wi / TC;
    iofs = face_ofs(hi, wi);
    oofs = face_ofs(ho, wo);

    joins = run_open && (pg[31:0] == run_page) && (int'(iofs) == int'(prev_in_ofs) + 1) &&
            (int'(oofs) == int'(prev_out_ofs) + 1) && (run_len < MAX_RUN);
    if (joins) begin
      run_len++;
    end else begin
      if (run_open) add_due(close_run(1'b0));
      run_open      = 1'b1;
      run_page      = pg[31:0];
      run_in_start  = iofs;
      run_out_start = oofs;
      run_len       = 1;
    end
    prev_in_ofs  = iofs;
    prev_out_ofs = oofs;
    if (pend) begin
      add_due(close_run(1'b1));
      run_open = 1'b0;
    end
  endtask

  task automatic report_bad(string what, seg_t exp_s, seg_t got_s);
    fail_count++;
    if (fail_count <= 10)
      $display({"%0t segment %s: expected page %h in %0d out %0d len %0d last %0b,",
                " got page %h in %0d out %0d len %0d last %0b"},
               $time, what, exp_s.in_page, exp_s.in_offset, exp_s.out_offset,
               exp_s.seg_length, exp_s.seg_last, got_s.in_page, got_s.in_offset,
               got_s.out_offset, got_s.seg_length, got_s.seg_last);
  endtask

  always @(posedge clk) begin
    seg_t got_s, exp_s;
    if (rst) begin
      shape_in_h  = DIM_W'(32);
      shape_in_w  = DIM_W'(32);
      shape_out_h = DIM_W'(32);
      shape_out_w = DIM_W'(32);
      run_open = 1'b0; run_page = '0; run_in_start = '0; run_out_start = '0;
      run_len = 0; prev_in_ofs = '0; prev_out_ofs = '0;
      segs_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IN_HEIGHT:  shape_in_h  = cfg_wdata;
          CFG_IN_WIDTH:   shape_in_w  = cfg_wdata;
          CFG_OUT_HEIGHT: shape_out_h = cfg_wdata;
          CFG_OUT_WIDTH:  shape_out_w = cfg_wdata;
          default: ;
        endcase
      end
      // segment beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got_s.in_page    = out_mon.in_page;
        got_s.in_offset  = out_mon.in_offset;
        got_s.out_offset = out_mon.out_offset;
        got_s.seg_length = out_mon.seg_length;
        got_s.seg_last   = out_mon.seg_last;
        if (segs_due.size() == 0) begin
          report_bad("unexpected", '0, got_s);
        end else begin
          exp_s = segs_due.pop_front();
          if (got_s !== exp_s) report_bad("mismatch", exp_s, got_s);
        end
      end
      // element beat
      if (in_mon.valid && in_mon.ready)
        take_element(in_mon.out_page, in_mon.tile_row, in_mon.tile_col, in_mon.page_end);
    end
    pending = segs_due.size();
  end

endmodule

@@ test/tiled_reshape_segment_mapper_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_reshape_segment_mapper_top_tb
// Drives element positions through several tensor shapes: a directed set of
// corner cases, then random tile walks that build long merged runs mixed
// with stray positions, with bursty input, a stalling output and one long
// output hold-off. Segments are checked by trsm_segment_checker.
// ----------------------------------------------------------------------------
module tiled_reshape_segment_mapper_top_tb;
  import trsm_pkg::*;

  localparam int SETTLE_CYCLES = 1500;
  localparam int PHASE_ITEMS   = 140;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;
  bit                   hold_off;
  int                   fail_count;
  int                   pending;
  int                   burst_left;

  trsm_in_if  in_ch ();
  trsm_out_if out_ch ();

  tiled_reshape_segment_mapper_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  trsm_segment_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // limit
  initial begin
    #60_000_000;
    $display("tiled_reshape_segment_mapper_top_tb failed");
    $finish;
  end

  // output stalls
  initial begin
    int mode, left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(50, 400);
      end
      left--;
      if (rst || hold_off) out_ch.ready <= 1'b0;
      else if (mode == 0) out_ch.ready <= 1'b1;
      else if (mode == 1) out_ch.ready <= ($urandom_range(0, 1) == 1);
      else out_ch.ready <= ($urandom_range(0, 4) == 0);
    end
  end

  // long output hold-off
  initial begin
    hold_off = 1'b0;
    wait (rst === 1'b0);
    repeat (20000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (8000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // one element beat, bursty
  task automatic send_element(bit [31:0] page, bit [4:0] row, bit [4:0] col, bit pend);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.out_page <= page;
    in_ch.tile_row <= row;
    in_ch.tile_col <= col;
    in_ch.page_end <= pend;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // face-ordered offset k back to a tile position
  task automatic send_face_pos(bit [31:0] page, int k, bit pend);
    int f, r;
    f = (k % 1024) / 256;
    r = k % 256;
    send_element(page, 5'((f / 2) * 16 + r / 16), 5'((f % 2) * 16 + r % 16), pend);
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_shape(int ih, int iw, int oh, int ow);
    logic [CFG_IDX_W-1:0] ids [4];
    int vals [4];
    ids  = '{CFG_IN_HEIGHT, CFG_IN_WIDTH, CFG_OUT_HEIGHT, CFG_OUT_WIDTH};
    vals = '{ih, iw, oh, ow};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= ids[i];
      cfg_wdata <= DIM_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    int shapes [7][4];
    int sent, len, start;
    bit [31:0] page;
    shapes = '{'{32, 32, 32, 32}, '{64, 64, 64, 64}, '{0, 0, 0, 0},
               '{65535, 65535, 65535, 65535}, '{1, 65535, 65535, 1},
               '{48, 40, 40, 48}, '{16, 64, 32, 32}};
    burst_left     = 0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_IN_HEIGHT;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.out_page = '0;
    in_ch.tile_row = '0;
    in_ch.tile_col = '0;
    in_ch.page_end = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: merged run, extremes, offset wrap, broken runs, page change
    send_element(32'd0, 5'd0, 5'd0, 1'b0);
    send_element(32'd0, 5'd0, 5'd1, 1'b0);
    send_element(32'd0, 5'd0, 5'd2, 1'b1);
    send_element(32'hFFFF_FFFF, 5'd31, 5'd31, 1'b1);
    send_element(32'd5, 5'd31, 5'd31, 1'b0);
    send_element(32'd5, 5'd0, 5'd0, 1'b1);
    send_element(32'd7, 5'd0, 5'd0, 1'b0);
    send_element(32'd7, 5'd0, 5'd2, 1'b0);
    send_element(32'd7, 5'd5, 5'd17, 1'b1);
    send_element(32'd8, 5'd15, 5'd15, 1'b0);
    send_element(32'd8, 5'd0, 5'd16, 1'b0);
    send_element(32'd9, 5'd0, 5'd17, 1'b1);
    send_element(32'h8000_0000, 5'd16, 5'd16, 1'b1);
    drain_and_settle();

    for (int ph = 0; ph < 7; ph++) begin
      write_shape(shapes[ph][0], shapes[ph][1], shapes[ph][2], shapes[ph][3]);
      if (ph == 3) begin
        // huge shapes and extreme pages
        send_element(32'hFFFF_FFFF, 5'd31, 5'd31, 1'b1);
        send_element(32'h0000_0000, 5'd31, 5'd0, 1'b1);
        send_element(32'h7FFF_FFFF, 5'd0, 5'd31, 1'b1);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          // stray position
          send_element($urandom, 5'($urandom), 5'($urandom), 1'($urandom));
          sent++;
        end else begin
          // tile walk in face order
          page  = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 40);
          start = $urandom_range(0, 1023);
          len   = $urandom_range(1, 40);
          for (int k = 0; k < len; k++)
            send_face_pos(page, start + k,
                          (k == len - 1) && ($urandom_range(0, 9) != 0));
          sent += len;
        end
      end
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("tiled_reshape_segment_mapper_top_tb passed");
    end else begin
      $display("tiled_reshape_segment_mapper_top_tb failed");
    end
    $finish;
  end

endmodule
